>>> hdl/vpn_pkg.sv
package vpn_pkg;

	localparam int POS_LAT   = 3;
	localparam int FRONT_LAT = 8;
	localparam int SQRT_LAT  = 32;
	localparam int DIV_STEPS = 15;
	localparam int DIV_LAT   = DIV_STEPS + 2;
	localparam int NRM_LAT   = FRONT_LAT + SQRT_LAT + DIV_LAT;
	localparam int POS_DLY   = NRM_LAT - POS_LAT;

	localparam logic [15:0] UNIT_Q14 = 16'd16384;

	localparam logic [2:0] REG_POS_ROW0 = 3'd0;
	localparam logic [2:0] REG_POS_ROW1 = 3'd1;
	localparam logic [2:0] REG_POS_ROW2 = 3'd2;
	localparam logic [2:0] REG_POS_ROW3 = 3'd3;
	localparam logic [2:0] REG_NRM_ROW0 = 3'd4;
	localparam logic [2:0] REG_NRM_ROW1 = 3'd5;
	localparam logic [2:0] REG_NRM_ROW2 = 3'd6;

	localparam logic [63:0] POS_ROW0_RST = 64'h0000_0000_0000_0100;
	localparam logic [63:0] POS_ROW1_RST = 64'h0000_0000_0100_0000;
	localparam logic [63:0] POS_ROW2_RST = 64'h0000_0100_0000_0000;
	localparam logic [63:0] POS_ROW3_RST = 64'h0100_0000_0000_0000;
	localparam logic [47:0] NRM_ROW0_RST = 48'h0000_0000_1000;
	localparam logic [47:0] NRM_ROW1_RST = 48'h0000_1000_0000;
	localparam logic [47:0] NRM_ROW2_RST = 48'h1000_0000_0000;

	// block-scaled magnitudes, signs and degenerate flag of the normal
	typedef struct packed {
		logic [2:0][30:0] mag;
		logic [2:0]       neg;
		logic             zero;
	} nrm_side_t;

	typedef struct packed {
		logic [3:0][31:0] pos;
		logic [2:0][15:0] nrm;
		logic [3:0][7:0]  col;
	} res_t;

endpackage

>>> hdl/vpn_pos.sv
module vpn_pos (
	input  logic             clk,
	input  logic             en,
	input  logic [3:0][31:0] pos,
	input  logic [3:0][63:0] row,
	output logic [3:0][31:0] res
);

	localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
	localparam logic signed [41:0] SAT_LO = -42'sd2147483648;

	logic signed [47:0] prod_s1 [4][4];
	logic signed [49:0] sum_d   [4];
	logic signed [49:0] sum_s2  [4];
	logic signed [41:0] shr_d   [4];
	logic [3:0][31:0]   sat_d;
	logic [3:0][31:0]   res_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= 48'($signed(pos[j])) * 48'($signed(row[i][16*j +: 16]));
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum_d[i] = 50'(prod_s1[i][0]) + 50'(prod_s1[i][1]) + 50'(prod_s1[i][2])
				+ 50'(prod_s1[i][3]) + 50'sd128;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum_d;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			shr_d[i] = 42'(sum_s2[i] >>> 8);
			if (shr_d[i] > SAT_HI) begin
				sat_d[i] = 32'h7FFF_FFFF;
			end else if (shr_d[i] < SAT_LO) begin
				sat_d[i] = 32'h8000_0000;
			end else begin
				sat_d[i] = shr_d[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= sat_d;
		end
	end

	assign res = res_s3;

endmodule

>>> hdl/vpn_nrm.sv
module vpn_nrm (
	input  logic                clk,
	input  logic                en,
	input  logic [2:0][15:0]    nrm,
	input  logic [2:0][47:0]    row,
	output logic [63:0]         sumsq,
	output vpn_pkg::nrm_side_t  side
);

	function automatic logic [2:0] lz8(input logic [7:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int k = 0; k < 8; k++) begin
			if (v[k]) begin
				r = 3'(7 - k);
			end
		end
		return r;
	endfunction

	logic signed [31:0] prod_s1 [3][3];
	logic signed [33:0] t_d     [3];
	logic [2:0][31:0]   mag_d;
	logic [2:0]         neg_d;
	logic [2:0][31:0]   mag_s2;
	logic [2:0]         neg_s2;
	logic [31:0]        mx_d;
	logic [2:0][31:0]   mag_s3;
	logic [2:0]         neg_s3;
	logic [31:0]        mx_s3;
	logic [2:0][31:0]   mag_s4;
	logic [2:0]         neg_s4;
	logic [3:0]         gnz_s4;
	logic [3:0][2:0]    glz_s4;
	logic [5:0]         lz_d;
	logic [2:0][31:0]   mag_s5;
	logic [2:0]         neg_s5;
	logic [5:0]         lz_s5;
	vpn_pkg::nrm_side_t sc_d;
	vpn_pkg::nrm_side_t side_s6;
	logic [2:0][61:0]   sq_s7;
	vpn_pkg::nrm_side_t side_s7;
	logic [63:0]        sum_s8;
	vpn_pkg::nrm_side_t side_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[i][j] <= 32'($signed(nrm[j])) * 32'($signed(row[i][16*j +: 16]));
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t_d[i]   = 34'(prod_s1[i][0]) + 34'(prod_s1[i][1]) + 34'(prod_s1[i][2]);
			neg_d[i] = t_d[i][33];
			mag_d[i] = neg_d[i] ? 32'(-t_d[i]) : 32'(t_d[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= mag_d;
			neg_s2 <= neg_d;
		end
	end

	always_comb begin
		mx_d = mag_s2[0];
		if (mag_s2[1] > mx_d) begin
			mx_d = mag_s2[1];
		end
		if (mag_s2[2] > mx_d) begin
			mx_d = mag_s2[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			mx_s3  <= mx_d;
		end
	end

	// leading zero count, split by byte
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			for (int g = 0; g < 4; g++) begin
				gnz_s4[g] <= |mx_s3[8*g +: 8];
				glz_s4[g] <= lz8(mx_s3[8*g +: 8]);
			end
		end
	end

	always_comb begin
		lz_d = 6'd32;
		for (int g = 0; g < 4; g++) begin
			if (gnz_s4[g]) begin
				lz_d = 6'((3 - g) * 8) + {3'b000, glz_s4[g]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			lz_s5  <= lz_d;
		end
	end

	// scale so the largest magnitude sits in [2^30, 2^31)
	always_comb begin
		sc_d.neg  = neg_s5;
		sc_d.zero = (lz_s5 == 6'd32);
		for (int i = 0; i < 3; i++) begin
			if (lz_s5 == 6'd0) begin
				sc_d.mag[i] = mag_s5[i][31:1];
			end else begin
				sc_d.mag[i] = 31'(mag_s5[i] << (lz_s5 - 6'd1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= sc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= 62'(side_s6.mag[i]) * 62'(side_s6.mag[i]);
			end
			side_s7 <= side_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s8  <= 64'(sq_s7[0]) + 64'(sq_s7[1]) + 64'(sq_s7[2]);
			side_s8 <= side_s7;
		end
	end

	assign sumsq = sum_s8;
	assign side  = side_s8;

endmodule

>>> hdl/vpn_sqrt.sv
module vpn_sqrt (
	input  logic                clk,
	input  logic                en,
	input  logic [63:0]         sumsq,
	input  vpn_pkg::nrm_side_t  side_in,
	output logic [31:0]         root,
	output vpn_pkg::nrm_side_t  side_out
);

	localparam int N = vpn_pkg::SQRT_LAT;

	logic [63:0]        rem_s  [1:N];
	logic [31:0]        root_s [1:N];
	vpn_pkg::nrm_side_t side_s [1:N];

	// one root bit per stage, most significant first
	for (genvar st = 0; st < N; st++) begin : g_step
		localparam int B = N - 1 - st;

		logic [63:0]        cur_rem;
		logic [31:0]        cur_root;
		vpn_pkg::nrm_side_t cur_side;
		logic [65:0]        trial;

		if (st == 0) begin : g_first
			assign cur_rem  = sumsq;
			assign cur_root = '0;
			assign cur_side = side_in;
		end else begin : g_next
			assign cur_rem  = rem_s[st];
			assign cur_root = root_s[st];
			assign cur_side = side_s[st];
		end

		assign trial = ({34'b0, cur_root} << (B + 1)) + (66'd1 << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[st+1] <= cur_side;
				if ({2'b00, cur_rem} >= trial) begin
					rem_s[st+1]  <= cur_rem - trial[63:0];
					root_s[st+1] <= cur_root | (32'd1 << B);
				end else begin
					rem_s[st+1]  <= cur_rem;
					root_s[st+1] <= cur_root;
				end
			end
		end
	end

	assign root     = root_s[N];
	assign side_out = side_s[N];

endmodule

>>> hdl/vpn_div.sv
module vpn_div (
	input  logic                clk,
	input  logic                en,
	input  logic [31:0]         root,
	input  vpn_pkg::nrm_side_t  side,
	output logic [2:0][15:0]    unit
);

	localparam int K = vpn_pkg::DIV_STEPS;

	logic [2:0][45:0] num_s1;
	logic [31:0]      den_s1;
	logic [2:0]       neg_s1;
	logic             zero_s1;

	logic [2:0][45:0] rem_s  [1:K];
	logic [2:0][14:0] quo_s  [1:K];
	logic [31:0]      den_s  [1:K];
	logic [2:0]       neg_s  [1:K];
	logic             zero_s [1:K];

	logic [2:0][15:0] unit_d;
	logic [2:0][15:0] unit_s;

	// rounded quotient: (mag * 2^14 + len/2) / len
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s1[i] <= {1'b0, side.mag[i], 14'b0} + {15'b0, root[31:1]};
			end
			den_s1  <= root;
			neg_s1  <= side.neg;
			zero_s1 <= side.zero;
		end
	end

	for (genvar st = 0; st < K; st++) begin : g_step
		localparam int B = K - 1 - st;

		logic [2:0][45:0] cur_rem;
		logic [2:0][14:0] cur_quo;
		logic [31:0]      cur_den;
		logic [2:0]       cur_neg;
		logic             cur_zero;
		logic [45:0]      dsh;

		if (st == 0) begin : g_first
			assign cur_rem  = num_s1;
			assign cur_quo  = '0;
			assign cur_den  = den_s1;
			assign cur_neg  = neg_s1;
			assign cur_zero = zero_s1;
		end else begin : g_next
			assign cur_rem  = rem_s[st];
			assign cur_quo  = quo_s[st];
			assign cur_den  = den_s[st];
			assign cur_neg  = neg_s[st];
			assign cur_zero = zero_s[st];
		end

		assign dsh = {14'b0, cur_den} << B;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[st+1]  <= cur_den;
				neg_s[st+1]  <= cur_neg;
				zero_s[st+1] <= cur_zero;
				for (int i = 0; i < 3; i++) begin
					if (cur_rem[i] >= dsh) begin
						rem_s[st+1][i] <= cur_rem[i] - dsh;
						quo_s[st+1][i] <= cur_quo[i] | (15'd1 << B);
					end else begin
						rem_s[st+1][i] <= cur_rem[i];
						quo_s[st+1][i] <= cur_quo[i];
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			unit_d[i] = {1'b0, quo_s[K][i]};
			if (unit_d[i] > vpn_pkg::UNIT_Q14) begin
				unit_d[i] = vpn_pkg::UNIT_Q14;
			end
			if (zero_s[K]) begin
				unit_d[i] = '0;
			end else if (neg_s[K][i]) begin
				unit_d[i] = 16'(-unit_d[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_s <= unit_d;
		end
	end

	assign unit = unit_s;

endmodule

>>> hdl/vertex_position_normal_transform_unit.sv
// Vertex transform: position by a 4x4 model matrix, normal by a 3x3 normal
// matrix then scaled to unit length, colour passed through.
// Input channel in_valid/in_ready carries one vertex word; output channel
// out_valid/out_ready carries the transformed vertex word.
// Matrices are written through cfg_we/cfg_index/cfg_data, by the user
// only while idle; the block itself does not enforce it. Normal path:
// 32-stage square root, 15-stage restoring divider. Throughput: one
// vertex per cycle while in_ready is high; all stages move together.
// A one-word skid register behind the pipeline keeps in_ready registered:
// when the receiver stalls, one more word is taken into the skid, then
// in_ready drops and the pipeline holds until out_ready returns.
// Reset clears all valid bits and loads identity matrices.
module vertex_position_normal_transform_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] pos_w,
	input  logic [15:0] nrm_x,
	input  logic [15:0] nrm_y,
	input  logic [15:0] nrm_z,
	input  logic [7:0]  col_r,
	input  logic [7:0]  col_g,
	input  logic [7:0]  col_b,
	input  logic [7:0]  col_a,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [31:0] out_w,
	output logic [15:0] out_nx,
	output logic [15:0] out_ny,
	output logic [15:0] out_nz,
	output logic [7:0]  out_r,
	output logic [7:0]  out_g,
	output logic [7:0]  out_b,
	output logic [7:0]  out_a
);

	localparam int LAT = vpn_pkg::NRM_LAT;
	localparam int DLY = vpn_pkg::POS_DLY;

	logic [3:0][63:0]   pos_row_q;
	logic [2:0][47:0]   nrm_row_q;

	logic               en;
	logic               hand;
	logic [LAT-1:0]     vld_q;

	logic [3:0][31:0]   pos_res;
	logic [3:0][31:0]   pos_dly_s [DLY];
	logic [3:0][7:0]    col_dly_s [LAT];

	logic [63:0]        sumsq;
	vpn_pkg::nrm_side_t side_f;
	logic [31:0]        root;
	vpn_pkg::nrm_side_t side_r;
	logic [2:0][15:0]   unit;

	vpn_pkg::res_t      res_d;
	vpn_pkg::res_t      out_q;
	vpn_pkg::res_t      skid_q;
	logic               out_valid_q;
	logic               skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_row_q[0] <= vpn_pkg::POS_ROW0_RST;
			pos_row_q[1] <= vpn_pkg::POS_ROW1_RST;
			pos_row_q[2] <= vpn_pkg::POS_ROW2_RST;
			pos_row_q[3] <= vpn_pkg::POS_ROW3_RST;
			nrm_row_q[0] <= vpn_pkg::NRM_ROW0_RST;
			nrm_row_q[1] <= vpn_pkg::NRM_ROW1_RST;
			nrm_row_q[2] <= vpn_pkg::NRM_ROW2_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				vpn_pkg::REG_POS_ROW0: pos_row_q[0] <= cfg_data;
				vpn_pkg::REG_POS_ROW1: pos_row_q[1] <= cfg_data;
				vpn_pkg::REG_POS_ROW2: pos_row_q[2] <= cfg_data;
				vpn_pkg::REG_POS_ROW3: pos_row_q[3] <= cfg_data;
				vpn_pkg::REG_NRM_ROW0: nrm_row_q[0] <= cfg_data[47:0];
				vpn_pkg::REG_NRM_ROW1: nrm_row_q[1] <= cfg_data[47:0];
				vpn_pkg::REG_NRM_ROW2: nrm_row_q[2] <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	assign en       = !skid_valid_q;
	assign in_ready = en;
	assign hand     = en && vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	vpn_pos u_pos (
		.clk (clk),
		.en  (en),
		.pos ({pos_w, pos_z, pos_y, pos_x}),
		.row (pos_row_q),
		.res (pos_res)
	);

	vpn_nrm u_nrm (
		.clk   (clk),
		.en    (en),
		.nrm   ({nrm_z, nrm_y, nrm_x}),
		.row   (nrm_row_q),
		.sumsq (sumsq),
		.side  (side_f)
	);

	vpn_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.sumsq    (sumsq),
		.side_in  (side_f),
		.root     (root),
		.side_out (side_r)
	);

	vpn_div u_div (
		.clk  (clk),
		.en   (en),
		.root (root),
		.side (side_r),
		.unit (unit)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			pos_dly_s[0] <= pos_res;
			col_dly_s[0] <= {col_a, col_b, col_g, col_r};
			for (int k = 1; k < DLY; k++) begin
				pos_dly_s[k] <= pos_dly_s[k-1];
			end
			for (int k = 1; k < LAT; k++) begin
				col_dly_s[k] <= col_dly_s[k-1];
			end
		end
	end

	assign res_d.pos = pos_dly_s[DLY-1];
	assign res_d.nrm = unit;
	assign res_d.col = col_dly_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= hand;
			end
		end else if (hand) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res_d;
		end else if (hand) begin
			skid_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_q.pos[0];
	assign out_y     = out_q.pos[1];
	assign out_z     = out_q.pos[2];
	assign out_w     = out_q.pos[3];
	assign out_nx    = out_q.nrm[0];
	assign out_ny    = out_q.nrm[1];
	assign out_nz    = out_q.nrm[2];
	assign out_r     = out_q.col[0];
	assign out_g     = out_q.col[1];
	assign out_b     = out_q.col[2];
	assign out_a     = out_q.col[3];

endmodule
